>>> rtl/rwl_pkg.sv
// Package with the sizes, codes and types shared by the reader-writer lock files.
`default_nettype none
package rwl_pkg;

	localparam int NUM_AGENTS = 16;
	localparam int AGENT_W = 4;
	localparam int ADDR_W = (NUM_AGENTS > 1) ? $clog2(NUM_AGENTS) : 1;
	localparam int DEPTH_W = $clog2(NUM_AGENTS + 1);
	localparam int COUNT_W = 5;
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
	localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(NUM_AGENTS);

	localparam logic [1:0] OP_ACQ_EXCL = 2'd0;
	localparam logic [1:0] OP_REL_EXCL = 2'd1;
	localparam logic [1:0] OP_ACQ_SHRD = 2'd2;
	localparam logic [1:0] OP_REL_SHRD = 2'd3;

	localparam logic [1:0] ST_GRANT = 2'd0;
	localparam logic [1:0] ST_QUEUED = 2'd1;
	localparam logic [1:0] ST_NONE = 2'd2;
	localparam logic [1:0] ST_ERROR = 2'd3;

	typedef struct packed {
		logic we;
		logic [ADDR_W-1:0] waddr;
		logic [AGENT_W-1:0] wdata;
		logic re;
		logic [ADDR_W-1:0] raddr;
	} stk_req_t;

endpackage
`default_nettype wire

>>> rtl/rwl_stack.sv
// Waiting-agent stack storage with one write port and one registered read port.
`default_nettype none
module rwl_stack
	import rwl_pkg::*;
(
	input wire logic clk,
	input wire stk_req_t req,
	output logic [AGENT_W-1:0] rdata
);

	logic [AGENT_W-1:0] mem [NUM_AGENTS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule
`default_nettype wire

>>> rtl/reader_writer_lock_arbiter.sv
// Top level of the reader-writer lock arbiter: request sequencer, holder counts and result port.
//
// A request is taken when start is high and busy is low. An acquire or a failing release
// gives one result, registered from the execute state. A release that wakes nobody gives its
// result from the wake state that follows execute, and one that wakes a writer gives it from
// the writer-pop state after wake. A release that wakes readers gives the first grant from the
// reader-pop state after wake and one more grant every cycle after that, newest waiter first,
// because each stack pop goes through the registered read port of its store.
// Every result is shown for exactly one cycle with done high and cannot be held off; last
// marks the final result of a request. Busy falls in the cycle that the final result is
// registered, so the next request may be taken while that result is on the ports.
`default_nettype none
module reader_writer_lock_arbiter
	import rwl_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [1:0] opcode,
	input wire logic [AGENT_W-1:0] agent_id,
	output logic done,
	output logic [1:0] status,
	output logic [AGENT_W-1:0] granted_agent,
	output logic grant_exclusive,
	output logic last
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_EXEC = 5'b00010,
		S_WAKE = 5'b00100,
		S_WPOP = 5'b01000,
		S_RPOP = 5'b10000
	} state_t;

	state_t state_q;
	logic [1:0] op_q;
	logic [AGENT_W-1:0] agent_q;
	logic [COUNT_W-1:0] rcount_q;
	logic wcount_q;
	logic [DEPTH_W-1:0] wdepth_q;
	logic [DEPTH_W-1:0] rdepth_q;

	logic done_q;
	logic [1:0] status_q;
	logic [AGENT_W-1:0] gagent_q;
	logic gexcl_q;
	logic last_q;

	stk_req_t wreq;
	stk_req_t rreq;
	logic [AGENT_W-1:0] wdata_rd;
	logic [AGENT_W-1:0] rdata_rd;

	logic [DEPTH_W-1:0] wdepth_m1;
	logic [DEPTH_W-1:0] rdepth_m1;
	logic excl_wait;
	logic wake_writer;

	assign wdepth_m1 = wdepth_q - DEPTH_W'(1);
	assign rdepth_m1 = rdepth_q - DEPTH_W'(1);
	assign excl_wait = (rcount_q != '0) || wcount_q || (wdepth_q != '0);
	assign wake_writer = !wcount_q && (rcount_q == '0) && (wdepth_q != '0);

	always_comb begin
		wreq = '0;
		rreq = '0;
		wreq.waddr = wdepth_q[ADDR_W-1:0];
		wreq.wdata = agent_q;
		wreq.raddr = wdepth_m1[ADDR_W-1:0];
		rreq.waddr = rdepth_q[ADDR_W-1:0];
		rreq.wdata = agent_q;
		rreq.raddr = rdepth_m1[ADDR_W-1:0];
		case (state_q)
			S_EXEC: begin
				if (op_q == OP_ACQ_EXCL && excl_wait && wdepth_q != DEPTH_FULL) begin
					wreq.we = 1'b1;
				end
				if (op_q == OP_ACQ_SHRD && wcount_q && rdepth_q != DEPTH_FULL) begin
					rreq.we = 1'b1;
				end
			end
			S_WAKE: begin
				if (wake_writer) begin
					wreq.re = 1'b1;
				end else if (rdepth_q != '0) begin
					rreq.re = 1'b1;
				end
			end
			S_RPOP: begin
				if (rdepth_q != '0) begin
					rreq.re = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	rwl_stack u_wstack (
		.clk(clk),
		.req(wreq),
		.rdata(wdata_rd)
	);

	rwl_stack u_rstack (
		.clk(clk),
		.req(rreq),
		.rdata(rdata_rd)
	);

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			op_q <= opcode;
			agent_q <= agent_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rcount_q <= '0;
			wcount_q <= 1'b0;
			wdepth_q <= '0;
			rdepth_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					done_q <= 1'b1;
					state_q <= S_IDLE;
					case (op_q)
						OP_ACQ_EXCL: begin
							if (excl_wait) begin
								if (wdepth_q != DEPTH_FULL) begin
									wdepth_q <= wdepth_q + DEPTH_W'(1);
								end
							end else begin
								wcount_q <= 1'b1;
							end
						end
						OP_REL_EXCL: begin
							if (wcount_q) begin
								wcount_q <= 1'b0;
								done_q <= 1'b0;
								state_q <= S_WAKE;
							end
						end
						OP_ACQ_SHRD: begin
							if (wcount_q) begin
								if (rdepth_q != DEPTH_FULL) begin
									rdepth_q <= rdepth_q + DEPTH_W'(1);
								end
							end else if (rcount_q != COUNT_MAX) begin
								rcount_q <= rcount_q + COUNT_W'(1);
							end
						end
						default: begin
							if (rcount_q != '0) begin
								rcount_q <= rcount_q - COUNT_W'(1);
								done_q <= 1'b0;
								state_q <= S_WAKE;
							end
						end
					endcase
				end
				S_WAKE: begin
					if (wake_writer) begin
						wdepth_q <= wdepth_m1;
						wcount_q <= 1'b1;
						state_q <= S_WPOP;
					end else if (rdepth_q != '0) begin
						rdepth_q <= rdepth_m1;
						state_q <= S_RPOP;
					end else begin
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_WPOP: begin
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_RPOP: begin
					done_q <= 1'b1;
					if (rcount_q != COUNT_MAX) begin
						rcount_q <= rcount_q + COUNT_W'(1);
					end
					if (rdepth_q != '0) begin
						rdepth_q <= rdepth_m1;
					end else begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_EXEC: begin
				status_q <= ST_ERROR;
				gagent_q <= '0;
				gexcl_q <= 1'b0;
				last_q <= 1'b1;
				case (op_q)
					OP_ACQ_EXCL: begin
						if (!excl_wait || wdepth_q != DEPTH_FULL) begin
							status_q <= excl_wait ? ST_QUEUED : ST_GRANT;
							gagent_q <= agent_q;
							gexcl_q <= 1'b1;
						end
					end
					OP_ACQ_SHRD: begin
						if (wcount_q ? (rdepth_q != DEPTH_FULL) : (rcount_q != COUNT_MAX)) begin
							status_q <= wcount_q ? ST_QUEUED : ST_GRANT;
							gagent_q <= agent_q;
						end
					end
					default: begin
					end
				endcase
			end
			S_WAKE: begin
				status_q <= ST_NONE;
				gagent_q <= '0;
				gexcl_q <= 1'b0;
				last_q <= 1'b1;
			end
			S_WPOP: begin
				status_q <= ST_GRANT;
				gagent_q <= wdata_rd;
				gexcl_q <= 1'b1;
				last_q <= 1'b1;
			end
			S_RPOP: begin
				status_q <= ST_GRANT;
				gagent_q <= rdata_rd;
				gexcl_q <= 1'b0;
				last_q <= (rdepth_q == '0);
			end
			default: begin
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign status = status_q;
	assign granted_agent = gagent_q;
	assign grant_exclusive = gexcl_q;
	assign last = last_q;

endmodule
`default_nettype wire
